[hw/rtl/sre_pkg.sv]
`default_nettype none

package sre_pkg;

  typedef enum logic [2:0] {
    REQ_INSERT  = 3'd0,
    REQ_DELETE  = 3'd1,
    REQ_SET     = 3'd2,
    REQ_REVERSE = 3'd3,
    REQ_SUM     = 3'd4,
    REQ_MAXSUM  = 3'd5
  } req_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2,
    ST_EMPTY = 2'd3
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_STREAM,
    S_INS_PUT,
    S_RV_RD_LO,
    S_RV_RD_HI,
    S_RV_SW_LO,
    S_RV_SW_HI,
    S_DONE
  } state_e;

  localparam int unsigned PosW = 11;
  localparam int unsigned ValW = 16;
  localparam int unsigned SumW = 32;

  typedef struct packed {
    logic [2:0]             req_type;
    logic [PosW-1:0]        position;
    logic [PosW-1:0]        count;
    logic signed [ValW-1:0] value;
  } in_t;

  typedef struct packed {
    logic [1:0]             status;
    logic signed [SumW-1:0] sum_value;
    logic [PosW-1:0]        length;
  } out_t;

endpackage

`default_nettype wire

[hw/rtl/sre_ram.sv]
`default_nettype none

// Simple dual-port store: one write port, one read port, registered read data.
module sre_ram #(
  parameter int unsigned DEPTH = 1024,
  parameter int unsigned AW    = $clog2(DEPTH)
) (
  input  wire logic                      clk_i,
  input  wire logic                      we_i,
  input  wire logic [AW-1:0]             waddr_i,
  input  wire logic [sre_pkg::ValW-1:0]  wdata_i,
  input  wire logic                      re_i,
  input  wire logic [AW-1:0]             raddr_i,
  output logic      [sre_pkg::ValW-1:0]  rdata_o
);

  logic [sre_pkg::ValW-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

`default_nettype wire

[hw/rtl/sequence_range_edit_engine.sv]
// Channel   Direction  Handshake              Payload
// request   in         in_valid_i/in_stall_o  in_data_i  (sre_pkg::in_t)
// result    out        out_valid_o/out_stall_i out_data_o (sre_pkg::out_t)
//
// Insert and delete move the elements behind the edit, set and sum visit the range, max-sum
// the whole sequence and reverse swaps pairs from both ends, all through the single read port
// and single write port of the element store; a failed request goes straight to the result.
// Reset empties the sequence at once; the store is not cleared and is never read unwritten.
// The input stalls until the result is loaded; a stalled result waits in the output register.
`default_nettype none

module sequence_range_edit_engine #(
  parameter int unsigned CAPACITY = 1024
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_stall_o,
  input  wire sre_pkg::in_t  in_data_i,
  output logic               out_valid_o,
  input  wire logic          out_stall_i,
  output sre_pkg::out_t      out_data_o
);

  // Address width of the store, width of the length register, and a comparison width that
  // holds both the length and any sum of two 11-bit request fields.
  localparam int unsigned AW = $clog2(CAPACITY);
  localparam int unsigned LW = $clog2(CAPACITY + 1);
  localparam int unsigned CW = ((LW > sre_pkg::PosW) ? LW : sre_pkg::PosW) + 1;
  localparam logic [CW-1:0] CapW = CW'(CAPACITY);

  sre_pkg::state_e state_q, state_d;
  sre_pkg::req_e   op_q, op_d;
  sre_pkg::status_e status_q, status_d;

  logic [LW-1:0] len_q, len_d;
  logic          out_valid_q, out_valid_d;
  sre_pkg::out_t res_q, res_d;

  logic signed [sre_pkg::ValW-1:0] val_q, val_d;
  logic [sre_pkg::PosW-1:0] cnt_q, cnt_d;
  logic [AW-1:0] rd_addr_q, rd_addr_d;
  logic [LW-1:0] rd_left_q, rd_left_d;
  logic          pend_q, pend_d;
  logic [AW-1:0] wa_q, wa_d;
  logic [AW-1:0] ins_pos_q, ins_pos_d;
  logic [AW-1:0] lo_q, lo_d, hi_q, hi_d;
  logic [sre_pkg::ValW-1:0] tmp_q, tmp_d;
  logic signed [sre_pkg::SumW-1:0] acc_q, acc_d, run_q, run_d;
  logic          first_q, first_d;

  // Store port signals.
  logic          we;
  logic [AW-1:0] waddr;
  logic [sre_pkg::ValW-1:0] wdata;
  logic          re;
  logic [AW-1:0] raddr;
  logic [sre_pkg::ValW-1:0] rdata;

  sre_ram #(
    .DEPTH (CAPACITY),
    .AW    (AW)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (re),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  // Request decoding, widened so that the bounds checks cannot overflow.
  logic [CW-1:0] pos_w, cnt_w, len_w, end_w;
  logic          range_ok, accept, issue, more_pairs, out_free;
  logic signed [sre_pkg::SumW-1:0] elem, run_sum, run_new;

  function automatic sre_pkg::req_e sre_sel_op(input logic [2:0] code);
    sre_pkg::req_e op;
    case (code)
      sre_pkg::REQ_INSERT:  op = sre_pkg::REQ_INSERT;
      sre_pkg::REQ_DELETE:  op = sre_pkg::REQ_DELETE;
      sre_pkg::REQ_SET:     op = sre_pkg::REQ_SET;
      sre_pkg::REQ_REVERSE: op = sre_pkg::REQ_REVERSE;
      sre_pkg::REQ_SUM:     op = sre_pkg::REQ_SUM;
      sre_pkg::REQ_MAXSUM:  op = sre_pkg::REQ_MAXSUM;
      default:              op = sre_pkg::REQ_REVERSE;
    endcase
    return op;
  endfunction

  assign pos_w    = CW'(in_data_i.position);
  assign cnt_w    = CW'(in_data_i.count);
  assign len_w    = CW'(len_q);
  assign end_w    = pos_w - CW'(1) + cnt_w;
  assign range_ok = (pos_w != '0) && (end_w <= len_w);
  assign accept   = in_valid_i && (state_q == sre_pkg::S_IDLE);
  assign issue    = (rd_left_q != '0);
  assign out_free = !out_valid_q || !out_stall_i;
  // Another pair remains to be swapped once the current one is written back.
  assign more_pairs = ((AW + 1)'(lo_q) + (AW + 1)'(2)) < (AW + 1)'(hi_q);

  assign elem    = sre_pkg::SumW'($signed(rdata));
  assign run_sum = run_q + elem;
  assign run_new = (run_sum > elem) ? run_sum : elem;

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      sre_pkg::S_IDLE: begin
        if (in_valid_i) begin
          state_d = sre_pkg::S_DONE;
          case (in_data_i.req_type)
            sre_pkg::REQ_INSERT: begin
              if (pos_w <= len_w && len_w < CapW) begin
                state_d = sre_pkg::S_STREAM;
              end
            end
            sre_pkg::REQ_DELETE, sre_pkg::REQ_SET, sre_pkg::REQ_SUM: begin
              if (range_ok) begin
                state_d = sre_pkg::S_STREAM;
              end
            end
            sre_pkg::REQ_REVERSE: begin
              if (range_ok && cnt_w > CW'(1)) begin
                state_d = sre_pkg::S_RV_RD_LO;
              end
            end
            sre_pkg::REQ_MAXSUM: begin
              if (len_q != '0) begin
                state_d = sre_pkg::S_STREAM;
              end
            end
            default: state_d = sre_pkg::S_DONE;
          endcase
        end
      end
      sre_pkg::S_STREAM: begin
        if (!issue && !pend_q) begin
          state_d = (op_q == sre_pkg::REQ_INSERT) ? sre_pkg::S_INS_PUT : sre_pkg::S_DONE;
        end
      end
      sre_pkg::S_INS_PUT:  state_d = sre_pkg::S_DONE;
      sre_pkg::S_RV_RD_LO: state_d = sre_pkg::S_RV_RD_HI;
      sre_pkg::S_RV_RD_HI: state_d = sre_pkg::S_RV_SW_LO;
      sre_pkg::S_RV_SW_LO: state_d = sre_pkg::S_RV_SW_HI;
      sre_pkg::S_RV_SW_HI: state_d = more_pairs ? sre_pkg::S_RV_SW_LO : sre_pkg::S_DONE;
      sre_pkg::S_DONE: begin
        if (out_free) begin
          state_d = sre_pkg::S_IDLE;
        end
      end
      default: state_d = sre_pkg::S_IDLE;
    endcase
  end

  // Datapath and store accesses.
  always_comb begin
    op_d        = op_q;
    status_d    = status_q;
    len_d       = len_q;
    val_d       = val_q;
    cnt_d       = cnt_q;
    rd_addr_d   = rd_addr_q;
    rd_left_d   = rd_left_q;
    pend_d      = 1'b0;
    wa_d        = wa_q;
    ins_pos_d   = ins_pos_q;
    lo_d        = lo_q;
    hi_d        = hi_q;
    tmp_d       = tmp_q;
    acc_d       = acc_q;
    run_d       = run_q;
    first_d     = first_q;
    out_valid_d = out_valid_q && out_stall_i;
    res_d       = res_q;
    we          = 1'b0;
    waddr       = wa_q;
    wdata       = rdata;
    re          = 1'b0;
    raddr       = rd_addr_q;

    case (state_q)
      sre_pkg::S_IDLE: begin
        if (accept) begin
          op_d      = sre_sel_op(in_data_i.req_type);
          status_d  = sre_pkg::ST_OK;
          val_d     = in_data_i.value;
          cnt_d     = in_data_i.count;
          acc_d     = '0;
          first_d   = 1'b1;
          rd_left_d = '0;
          case (in_data_i.req_type)
            sre_pkg::REQ_INSERT: begin
              if (pos_w > len_w) begin
                status_d = sre_pkg::ST_RANGE;
              end else if (len_w >= CapW) begin
                status_d = sre_pkg::ST_FULL;
              end
              rd_left_d = LW'(len_w - pos_w);
              rd_addr_d = AW'(len_w - CW'(1));
              ins_pos_d = AW'(pos_w);
            end
            sre_pkg::REQ_DELETE: begin
              if (!range_ok) begin
                status_d = sre_pkg::ST_RANGE;
              end
              rd_left_d = (cnt_w == '0) ? '0 : LW'(len_w - end_w);
              rd_addr_d = AW'(end_w);
            end
            sre_pkg::REQ_SET, sre_pkg::REQ_SUM: begin
              if (!range_ok) begin
                status_d = sre_pkg::ST_RANGE;
              end
              rd_left_d = LW'(cnt_w);
              rd_addr_d = AW'(pos_w - CW'(1));
            end
            sre_pkg::REQ_REVERSE: begin
              if (!range_ok) begin
                status_d = sre_pkg::ST_RANGE;
              end
              lo_d = AW'(pos_w - CW'(1));
              hi_d = AW'(end_w - CW'(1));
            end
            sre_pkg::REQ_MAXSUM: begin
              if (len_q == '0) begin
                status_d = sre_pkg::ST_EMPTY;
              end
              rd_left_d = len_q;
              rd_addr_d = '0;
            end
            default: status_d = sre_pkg::ST_OK;
          endcase
        end
      end

      sre_pkg::S_STREAM: begin
        // Issue side: one element address a cycle.
        if (issue) begin
          rd_left_d = rd_left_q - LW'(1);
          rd_addr_d = (op_q == sre_pkg::REQ_INSERT) ? rd_addr_q - AW'(1) : rd_addr_q + AW'(1);
          if (op_q == sre_pkg::REQ_SET) begin
            we    = 1'b1;
            waddr = rd_addr_q;
            wdata = val_q;
          end else begin
            re     = 1'b1;
            pend_d = 1'b1;
            wa_d   = (op_q == sre_pkg::REQ_INSERT) ? rd_addr_q + AW'(1)
                                                   : rd_addr_q - AW'(cnt_q);
          end
        end
        // Return side: the element read in the previous cycle.
        if (pend_q) begin
          case (op_q)
            sre_pkg::REQ_INSERT, sre_pkg::REQ_DELETE: begin
              we    = 1'b1;
              waddr = wa_q;
              wdata = rdata;
            end
            sre_pkg::REQ_SUM: acc_d = acc_q + elem;
            sre_pkg::REQ_MAXSUM: begin
              first_d = 1'b0;
              if (first_q) begin
                run_d = elem;
                acc_d = elem;
              end else begin
                run_d = run_new;
                acc_d = (run_new > acc_q) ? run_new : acc_q;
              end
            end
            default: acc_d = acc_q;
          endcase
        end
        if (!issue && !pend_q && op_q == sre_pkg::REQ_DELETE) begin
          len_d = len_q - LW'(cnt_q);
        end
      end

      sre_pkg::S_INS_PUT: begin
        we    = 1'b1;
        waddr = ins_pos_q;
        wdata = val_q;
        len_d = len_q + LW'(1);
      end

      sre_pkg::S_RV_RD_LO: begin
        re    = 1'b1;
        raddr = lo_q;
      end

      sre_pkg::S_RV_RD_HI: begin
        re    = 1'b1;
        raddr = hi_q;
        tmp_d = rdata;
      end

      sre_pkg::S_RV_SW_LO: begin
        // The upper element has arrived and goes to the lower slot.
        we    = 1'b1;
        waddr = lo_q;
        wdata = rdata;
        if (more_pairs) begin
          re    = 1'b1;
          raddr = lo_q + AW'(1);
        end
      end

      sre_pkg::S_RV_SW_HI: begin
        we    = 1'b1;
        waddr = hi_q;
        wdata = tmp_q;
        if (more_pairs) begin
          re    = 1'b1;
          raddr = hi_q - AW'(1);
          tmp_d = rdata;
          lo_d  = lo_q + AW'(1);
          hi_d  = hi_q - AW'(1);
        end
      end

      sre_pkg::S_DONE: begin
        if (out_free) begin
          out_valid_d         = 1'b1;
          res_d.status        = status_q;
          res_d.sum_value     = acc_q;
          res_d.length        = sre_pkg::PosW'(len_w);
        end
      end

      default: out_valid_d = out_valid_q && out_stall_i;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= sre_pkg::S_IDLE;
      len_q       <= '0;
      out_valid_q <= 1'b0;
      pend_q      <= 1'b0;
      rd_left_q   <= '0;
    end else begin
      state_q     <= state_d;
      len_q       <= len_d;
      out_valid_q <= out_valid_d;
      pend_q      <= pend_d;
      rd_left_q   <= rd_left_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q      <= op_d;
    status_q  <= status_d;
    val_q     <= val_d;
    cnt_q     <= cnt_d;
    rd_addr_q <= rd_addr_d;
    wa_q      <= wa_d;
    ins_pos_q <= ins_pos_d;
    lo_q      <= lo_d;
    hi_q      <= hi_d;
    tmp_q     <= tmp_d;
    acc_q     <= acc_d;
    run_q     <= run_d;
    first_q   <= first_d;
    res_q     <= res_d;
  end

  assign in_stall_o  = (state_q != sre_pkg::S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = res_q;

endmodule

`default_nettype wire

[hw/rtl/sre_checker.sv]
`default_nettype none

module sre_checker #(
  parameter int unsigned CAPACITY = 1024
) (
  input wire logic          clk_i,
  input wire logic          rst_ni,
  input wire logic          in_valid_i,
  input wire logic          in_stall_o,
  input wire logic          out_valid_o,
  input wire logic          out_stall_i,
  input wire sre_pkg::out_t out_data_o
);

  localparam logic [sre_pkg::PosW-1:0] CapLen = sre_pkg::PosW'(CAPACITY);

  // A stalled result transaction keeps its payload.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("result changed while stalled");

  // A failed request carries no sum.
  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.status != sre_pkg::ST_OK) |-> out_data_o.sum_value == '0)
    else $error("failed request with nonzero sum");

  // A full store is reported only at capacity.
  a_full_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.status == sre_pkg::ST_FULL) |-> out_data_o.length == CapLen)
    else $error("store full reported below capacity");

  // An accepted request is still being worked on in the next cycle.
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("request accepted without going busy");

endmodule

bind sequence_range_edit_engine sre_checker #(.CAPACITY(CAPACITY)) u_sre_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);

`default_nettype wire

[dv/tb_sequence_range_edit_engine.sv]
`default_nettype none

module tb_sequence_range_edit_engine;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned Depth = 1024;
  // Length the sequence is grown to before the whole-sequence walks.
  localparam int unsigned FillLen = 300;
  // Length of the receiver's long hold-off, in cycles.
  localparam int unsigned LongHold = 3000;
  // The slowest legal transaction walks the whole store once, and the watchdog is paused
  // during the receiver's long hold-off, so this idle limit is ample.
  localparam int unsigned IdleLimit = 20000;

  logic clk_i;
  logic rst_ni;
  logic in_valid_i;
  logic in_stall_o;
  sre_pkg::in_t  in_data_i;
  logic out_valid_o;
  logic out_stall_i;
  sre_pkg::out_t out_data_o;

  sequence_range_edit_engine #(.CAPACITY(Depth)) u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Shadow length of the sequence, kept by the stimulus generator so that it can
  // aim ranges at the current length, and a copy of the sequence kept by the predictor.
  logic signed [15:0] shadow_seq[Depth];
  int unsigned        shadow_len;
  logic signed [15:0] model_seq[Depth];
  int unsigned        model_len;

  sre_pkg::in_t  pending_reqs[$];
  sre_pkg::out_t expected_results[$];
  int unsigned errors;
  int unsigned n_sent, n_checked;
  int unsigned req_seen[8];
  int unsigned status_seen[4];
  bit          stim_done;
  bit          hold_sender;   // the sender pauses while this is set
  bit          long_hold;     // asks the receiver for one long hold-off
  bit          long_done;     // set by the receiver once the hold-off is over
  int unsigned idle_cycles;

  // Predicts the result of one request and updates the predictor's sequence.
  function automatic sre_pkg::out_t predict_edit(sre_pkg::in_t req);
    sre_pkg::out_t r;
    int unsigned p, c, lo, hi;
    logic signed [15:0] t;
    longint s, run, best;
    p = req.position;
    c = req.count;
    r.status = sre_pkg::ST_OK;
    s = 0;
    case (req.req_type)
      sre_pkg::REQ_INSERT: begin
        if (p > model_len) r.status = sre_pkg::ST_RANGE;
        else if (model_len >= Depth) r.status = sre_pkg::ST_FULL;
        else begin
          for (int i = model_len; i > p; i--) model_seq[i] = model_seq[i-1];
          model_seq[p] = req.value;
          model_len++;
        end
      end
      sre_pkg::REQ_DELETE, sre_pkg::REQ_SET, sre_pkg::REQ_REVERSE, sre_pkg::REQ_SUM: begin
        if (p < 1 || p - 1 + c > model_len) r.status = sre_pkg::ST_RANGE;
        else if (req.req_type == sre_pkg::REQ_DELETE) begin
          for (int i = p - 1; i + c < model_len; i++) model_seq[i] = model_seq[i+c];
          model_len -= c;
        end else if (req.req_type == sre_pkg::REQ_SET) begin
          for (int i = 0; i < c; i++) model_seq[p-1+i] = req.value;
        end else if (req.req_type == sre_pkg::REQ_REVERSE) begin
          if (c > 1) begin
            lo = p - 1;
            hi = p - 2 + c;
            while (lo < hi) begin
              t = model_seq[lo];
              model_seq[lo] = model_seq[hi];
              model_seq[hi] = t;
              lo++;
              hi--;
            end
          end
        end else begin
          for (int i = 0; i < c; i++) s += model_seq[p-1+i];
        end
      end
      sre_pkg::REQ_MAXSUM: begin
        if (model_len == 0) r.status = sre_pkg::ST_EMPTY;
        else begin
          run = model_seq[0];
          best = run;
          for (int i = 1; i < model_len; i++) begin
            run = (run + model_seq[i] > model_seq[i]) ? run + model_seq[i] : model_seq[i];
            if (run > best) best = run;
          end
          s = best;
        end
      end
      default: ;
    endcase
    r.sum_value = s[31:0];
    r.length = model_len[10:0];
    return r;
  endfunction

  // Keeps the generator's own picture of the sequence length up to date.
  function automatic void track_length(sre_pkg::in_t req);
    int unsigned p, c;
    p = req.position;
    c = req.count;
    if (req.req_type == sre_pkg::REQ_INSERT && p <= shadow_len && shadow_len < Depth)
      shadow_len++;
    if (req.req_type == sre_pkg::REQ_DELETE && p >= 1 && p - 1 + c <= shadow_len)
      shadow_len -= c;
  endfunction

  task automatic queue_req(logic [2:0] kind, int unsigned p, int unsigned c, logic [15:0] v);
    sre_pkg::in_t req;
    req.req_type = kind;
    req.position = p[10:0];
    req.count = c[10:0];
    req.value = v;
    track_length(req);
    pending_reqs.push_back(req);
  endtask

  // A random well-aimed request, with an occasional out-of-range or unknown-kind one.
  task automatic queue_random_req();
    int unsigned kind, p, c, roll;
    logic [15:0] v;
    roll = $urandom_range(99);
    v = (roll < 10) ? (($urandom_range(1)) ? 16'h7fff : 16'h8000) : 16'($urandom);
    kind = $urandom_range(99);
    // Bias toward inserts while the sequence is short so it grows usefully.
    if (kind < (shadow_len < 40 ? 50 : 25)) begin
      p = $urandom_range(shadow_len);
      if (roll > 95) p = shadow_len + 1 + $urandom_range(3);
      queue_req(sre_pkg::REQ_INSERT, p, $urandom_range(2047), v);
    end else if (kind < 97) begin
      kind = (kind < 45) ? sre_pkg::REQ_DELETE : (kind < 62) ? sre_pkg::REQ_SET :
             (kind < 77) ? sre_pkg::REQ_REVERSE : (kind < 90) ? sre_pkg::REQ_SUM :
             sre_pkg::REQ_MAXSUM;
      if (roll > 92 || shadow_len == 0) begin
        p = $urandom_range(2047);
        c = $urandom_range(2047);
      end else begin
        p = $urandom_range(shadow_len, 1);
        c = $urandom_range(shadow_len - p + 1);
        if (kind == sre_pkg::REQ_DELETE && c > 8) c = $urandom_range(8);
      end
      queue_req(kind[2:0], p, c, v);
    end else begin
      queue_req(3'($urandom_range(7, 6)), $urandom_range(2047), $urandom_range(2047), v);
    end
  endtask

  // Stimulus: directed corner cases first, then random traffic in phases.
  initial begin
    shadow_len = 0;
    stim_done = 0;
    hold_sender = 0;
    long_hold = 0;
    wait (rst_ni === 1'b1);
    queue_req(sre_pkg::REQ_MAXSUM, 0, 0, 0);          // max-sum on an empty sequence
    queue_req(sre_pkg::REQ_INSERT, 1, 0, 16'h1234);   // insert past the end
    queue_req(sre_pkg::REQ_SUM, 0, 0, 0);             // position zero is out of bounds
    queue_req(sre_pkg::REQ_INSERT, 0, 0, 16'h7fff);
    queue_req(sre_pkg::REQ_INSERT, 1, 0, 16'h8000);
    queue_req(sre_pkg::REQ_INSERT, 0, 2047, 16'hffff);
    queue_req(sre_pkg::REQ_INSERT, 3, 0, 16'h0005);
    queue_req(sre_pkg::REQ_SUM, 1, 4, 0);
    queue_req(sre_pkg::REQ_SUM, 2, 0, 0);             // empty range
    queue_req(sre_pkg::REQ_SUM, 2, 4, 0);             // range runs off the end
    queue_req(sre_pkg::REQ_REVERSE, 1, 4, 0);
    queue_req(sre_pkg::REQ_REVERSE, 2, 1, 0);
    queue_req(sre_pkg::REQ_SET, 2, 2, 16'h8000);
    queue_req(sre_pkg::REQ_SET, 2047, 2047, 16'h7fff);
    queue_req(sre_pkg::REQ_MAXSUM, 2047, 2047, 0);
    queue_req(sre_pkg::REQ_DELETE, 3, 0, 0);
    queue_req(sre_pkg::REQ_DELETE, 1, 2, 0);
    queue_req(sre_pkg::REQ_DELETE, 1, 3, 0);
    queue_req(3'd6, 1, 1, 16'h5555);
    queue_req(3'd7, 2047, 2047, 16'haaaa);
    queue_req(sre_pkg::REQ_MAXSUM, 0, 0, 0);
    wait (pending_reqs.size() == 0);

    // Grow the sequence with random values, run the whole-sequence walks,
    // then trim back down.
    hold_sender = 1;
    wait (expected_results.size() == 0 && !in_valid_i);
    hold_sender = 0;
    while (shadow_len < FillLen) queue_req(sre_pkg::REQ_INSERT, shadow_len, 0, 16'($urandom));
    queue_req(sre_pkg::REQ_INSERT, FillLen + 1, 0, 16'h0001);   // insert past the end
    queue_req(sre_pkg::REQ_INSERT, 0, 0, 16'h0001);
    queue_req(sre_pkg::REQ_SUM, 1, FillLen + 1, 0);
    queue_req(sre_pkg::REQ_MAXSUM, 0, 0, 0);
    queue_req(sre_pkg::REQ_REVERSE, 1, FillLen + 1, 0);
    queue_req(sre_pkg::REQ_SUM, 1, FillLen + 1, 0);
    queue_req(sre_pkg::REQ_SET, 1, FillLen + 1, 16'h7fff);
    queue_req(sre_pkg::REQ_SUM, 1, FillLen + 1, 0);          // most positive total
    queue_req(sre_pkg::REQ_SET, 1, FillLen + 1, 16'h8000);
    queue_req(sre_pkg::REQ_SUM, 1, FillLen + 1, 0);          // most negative total
    queue_req(sre_pkg::REQ_MAXSUM, 0, 0, 0);
    queue_req(sre_pkg::REQ_DELETE, 1, FillLen - 20, 0);
    wait (pending_reqs.size() == 0);

    // Long receiver hold-off while the sender keeps offering requests.
    long_hold = 1;
    repeat (30) queue_random_req();
    wait (long_done);
    long_hold = 0;

    // Random phases, each drained fully before the next.
    for (int ph = 0; ph < 3; ph++) begin
      repeat (80) queue_random_req();
      wait (pending_reqs.size() == 0);
      hold_sender = 1;
      wait (expected_results.size() == 0 && !in_valid_i);
      hold_sender = 0;
    end
    stim_done = 1;
  end

  // Driver: bursts of transactions separated by random gaps.
  int unsigned burst_left, gap_left;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      in_data_i <= '0;
      burst_left <= 0;
      gap_left <= 0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        expected_results.push_back(predict_edit(in_data_i));
        req_seen[in_data_i.req_type]++;
        n_sent++;
      end
      if (!in_valid_i || !in_stall_o) begin
        // The previous transaction (if any) has gone; choose what comes next.
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
          in_valid_i <= 1'b0;
        end else if (!hold_sender && pending_reqs.size() > 0) begin
          in_valid_i <= 1'b1;
          in_data_i <= pending_reqs.pop_front();
          if (burst_left == 0) begin
            burst_left <= $urandom_range(20, 1);
            gap_left <= ($urandom_range(3) == 0) ? 0 : $urandom_range(6);
          end else begin
            burst_left <= burst_left - 1;
          end
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Receiver stall pattern: alternating stretches of random stalls and free cycles, and one
  // long hold-off counted here when the stimulus asks for it.
  int unsigned stall_left;
  bit          stall_mode;
  int unsigned hold_count;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      stall_left <= 0;
      stall_mode <= 1'b0;
      hold_count <= 0;
      long_done <= 1'b0;
    end else if (long_hold && !long_done) begin
      out_stall_i <= 1'b1;
      hold_count <= hold_count + 1;
      if (hold_count + 1 >= LongHold) long_done <= 1'b1;
    end else if (stall_left == 0) begin
      stall_mode <= ~stall_mode;
      stall_left <= $urandom_range(stall_mode ? 40 : 8, 1);
      out_stall_i <= 1'b0;
    end else begin
      stall_left <= stall_left - 1;
      out_stall_i <= stall_mode ? 1'b0 : ($urandom_range(2) != 0);
    end
  end

  // Monitor: compares each result transaction with the oldest prediction.
  sre_pkg::out_t exp_r;
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_results.size() == 0) begin
        $error("result with no request outstanding: %p", out_data_o);
        errors++;
      end else begin
        exp_r = expected_results.pop_front();
        if (out_data_o.status !== exp_r.status) begin
          $error("status: expected %0d, got %0d", exp_r.status, out_data_o.status);
          errors++;
        end
        if (out_data_o.sum_value !== exp_r.sum_value) begin
          $error("sum_value: expected %0d, got %0d", exp_r.sum_value, out_data_o.sum_value);
          errors++;
        end
        if (out_data_o.length !== exp_r.length) begin
          $error("length: expected %0d, got %0d", exp_r.length, out_data_o.length);
          errors++;
        end
      end
      if (out_data_o.status <= 3) status_seen[out_data_o.status]++;
      n_checked++;
    end
  end

  // Watchdog: counts cycles in which neither channel completes a transaction, outside the long hold-off.
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)
        || long_hold) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IdleLimit && !(stim_done && expected_results.size() == 0)) begin
        $display("Timeout with %0d results outstanding", expected_results.size());
        $display("Mismatches found");
        $finish;
      end
    end
  end

  initial begin
    errors = 0;
    n_sent = 0;
    n_checked = 0;
    idle_cycles = 0;
    model_len = 0;
    rst_ni = 1'b0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    wait (stim_done && expected_results.size() == 0);
    repeat (50) @(posedge clk_i);
    $display("Checked %0d results for %0d requests; kinds 0-7 seen: %0d %0d %0d %0d %0d %0d %0d %0d",
             n_checked, n_sent, req_seen[0], req_seen[1], req_seen[2], req_seen[3],
             req_seen[4], req_seen[5], req_seen[6], req_seen[7]);
    $display("Statuses ok/range/full/empty: %0d %0d %0d %0d",
             status_seen[0], status_seen[1], status_seen[2], status_seen[3]);
    if (errors == 0 && expected_results.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

`default_nettype wire
